FILE: rtl/core/rsdh_pkg.sv
// Shared constants, register codes and types for the radial shell density histogram.
`timescale 1ns / 1ps

package rsdh_pkg;

  // Field widths
  localparam int POS_W      = 24;
  localparam int DENS_W     = 32;
  localparam int SEL_W      = 7;
  localparam int SPB_W      = 16;
  localparam int LIM_W      = 8;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 32;
  localparam int MEAN1_W    = 31;
  localparam int MEAN2_W    = 63;
  localparam int SQ_FRAC    = 16;

  // Shell storage
  localparam int MAX_SHELLS = 128;
  localparam int SHELL_AW   = $clog2(MAX_SHELLS);

  // Distance path
  localparam int D2_W       = 2 * POS_W + 2;
  localparam int ROOT_W     = POS_W + 1;
  localparam int IDX_FULL_W = ROOT_W + SPB_W - POS_W;

  // Shared iterative unit
  localparam int ITER_W     = SUM_W;
  localparam int REM_W      = CNT_W + 2;
  localparam int STEP_W     = $clog2(ITER_W);
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = ITER_W;
  localparam int MUL_W      = 32;

  // Stream payloads
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 136;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_CENTER_Z       = 3'd2,
    REG_SHELLS_PER_BOX = 3'd3,
    REG_SHELLS_IN_USE  = 3'd4
  } cfg_reg_t;

  localparam logic [POS_W-1:0] CENTER_X_RST       = POS_W'(6059981);
  localparam logic [POS_W-1:0] CENTER_Y_RST       = POS_W'(3534255);
  localparam logic [POS_W-1:0] CENTER_Z_RST       = POS_W'(115381);
  localparam logic [SPB_W-1:0] SHELLS_PER_BOX_RST = SPB_W'(10000);
  localparam logic [LIM_W-1:0] SHELLS_IN_USE_RST  = LIM_W'(100);

  typedef enum logic {
    IU_SQRT = 1'b0,
    IU_DIV  = 1'b1
  } iu_op_t;

  typedef struct packed {
    logic   start;
    iu_op_t op;
  } iu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iu_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sq_sum;
    logic [SUM_W-1:0] sum;
  } shell_entry_t;

endpackage

FILE: rtl/core/radial_shell_density_histogram.sv
// Top level: radial shell density histogram with sequencer, shared multiplier and shell RAM.
`timescale 1ns / 1ps
//
// Input stream (s_*): one transaction is either a particle (s_tuser = 0) or a
// read-and-clear request for one shell (s_tuser = 1). s_tready is high only
// while the sequencer is idle; each transaction is worked on to the end
// before the next one is taken.
// Particle: three squared offsets go through one 32x32 multiplier, the
// 25-bit root comes from the shared bit-serial unit, then shell index, RAM
// read and saturating update. A particle with non-positive density is
// dropped in the accept cycle.
// Read: two 64-step divisions (sum / count and squared sum / count) on the
// same shared unit. An empty shell skips them.
// Output stream (m_*): one transaction per read request. The result sits in
// an output register; the block keeps taking particles while it waits, and
// a later read holds in its final step until m_tready frees the register.
// Configuration: cfg_we writes cfg_data to register cfg_index; write only
// while idle. Indexes above four are ignored.
// Reset: synchronous rst restores register defaults and clears all 128
// shell valid bits at once, so every shell reads as empty; no sweep needed.

module radial_shell_density_histogram (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], density[103:72],
  // shell_select[110:104], zero pad [111]
  input  logic [rsdh_pkg::IN_TDATA_W-1:0]     s_tdata,
  // kind[0]
  input  logic                                s_tuser,
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // shell_index[6:0], mean_density[37:7], mean_density_sq[100:38],
  // particle_count[132:101], zero pad [135:133]
  output logic [rsdh_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [rsdh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsdh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIST,
    S_SQRT_GO,
    S_SQRT,
    S_IDX,
    S_CHK,
    S_ACC,
    S_RADDR,
    S_RDATA,
    S_DIV1,
    S_DIV2_GO,
    S_DIV2,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [rsdh_pkg::POS_W-1:0] center_x;
  logic [rsdh_pkg::POS_W-1:0] center_y;
  logic [rsdh_pkg::POS_W-1:0] center_z;
  logic [rsdh_pkg::SPB_W-1:0] shells_per_box;
  logic [rsdh_pkg::LIM_W-1:0] shells_in_use;

  // Captured transaction
  logic [rsdh_pkg::POS_W-1:0]  pos_x;
  logic [rsdh_pkg::POS_W-1:0]  pos_y;
  logic [rsdh_pkg::POS_W-1:0]  pos_z;
  logic [rsdh_pkg::DENS_W-1:0] density;
  logic [rsdh_pkg::SEL_W-1:0]  sel;

  // Working registers
  logic [1:0]                    axis;
  logic [rsdh_pkg::D2_W-1:0]     d2;
  logic [rsdh_pkg::SHELL_AW-1:0] idx;
  logic [rsdh_pkg::SUM_W-1:0]    sq_sum_r;
  logic [rsdh_pkg::CNT_W-1:0]    cnt_r;
  logic [rsdh_pkg::MEAN1_W-1:0]  mean1_r;
  logic [rsdh_pkg::MEAN2_W-1:0]  mean2_r;
  logic [rsdh_pkg::MAX_SHELLS-1:0] vld;

  // Output register
  logic [rsdh_pkg::SEL_W-1:0]   out_index;
  logic [rsdh_pkg::MEAN1_W-1:0] out_mean;
  logic [rsdh_pkg::MEAN2_W-1:0] out_mean_sq;
  logic [rsdh_pkg::CNT_W-1:0]   out_count;

  // Shared multiplier
  logic [rsdh_pkg::MUL_W-1:0]   mul_a;
  logic [rsdh_pkg::MUL_W-1:0]   mul_b;
  logic [2*rsdh_pkg::MUL_W-1:0] prod;

  // Offset of the current axis
  logic [rsdh_pkg::POS_W-1:0] ax_p;
  logic [rsdh_pkg::POS_W-1:0] ax_c;
  logic [rsdh_pkg::POS_W-1:0] ax_d;

  // Shell index check
  logic [rsdh_pkg::IDX_FULL_W-1:0] idx_full;
  logic                            in_range;

  // Shell RAM
  logic                                      ram_we;
  logic [rsdh_pkg::SHELL_AW-1:0]             ram_raddr;
  logic [$bits(rsdh_pkg::shell_entry_t)-1:0] ram_rdata;
  rsdh_pkg::shell_entry_t                    rd_entry;
  rsdh_pkg::shell_entry_t                    acc_entry;
  rsdh_pkg::shell_entry_t                    new_entry;
  logic [rsdh_pkg::SHELL_AW-1:0]             rd_shell;

  // Saturating sums
  logic [rsdh_pkg::SUM_W:0] sum_add;
  logic [rsdh_pkg::SUM_W:0] sq_add;

  // Shared iterative unit
  rsdh_pkg::iu_ctrl_t           iu_ctrl;
  rsdh_pkg::iu_stat_t           iu_stat;
  logic [rsdh_pkg::ITER_W-1:0]  iu_num;
  logic [rsdh_pkg::CNT_W-1:0]   iu_den;
  logic [rsdh_pkg::ITER_W-1:0]  iu_result;

  logic in_xfer;
  logic out_free;
  logic dens_pos;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign dens_pos = !s_tdata[103] && (s_tdata[103:72] != '0);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= rsdh_pkg::CENTER_X_RST;
      center_y       <= rsdh_pkg::CENTER_Y_RST;
      center_z       <= rsdh_pkg::CENTER_Z_RST;
      shells_per_box <= rsdh_pkg::SHELLS_PER_BOX_RST;
      shells_in_use  <= rsdh_pkg::SHELLS_IN_USE_RST;
    end else if (cfg_we) begin
      case (rsdh_pkg::cfg_reg_t'(cfg_index))
        rsdh_pkg::REG_CENTER_X:       center_x       <= cfg_data[rsdh_pkg::POS_W-1:0];
        rsdh_pkg::REG_CENTER_Y:       center_y       <= cfg_data[rsdh_pkg::POS_W-1:0];
        rsdh_pkg::REG_CENTER_Z:       center_z       <= cfg_data[rsdh_pkg::POS_W-1:0];
        rsdh_pkg::REG_SHELLS_PER_BOX: shells_per_box <= cfg_data[rsdh_pkg::SPB_W-1:0];
        rsdh_pkg::REG_SHELLS_IN_USE:  shells_in_use  <= cfg_data[rsdh_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // |p - c| for the axis being squared
  always_comb begin
    case (axis)
      2'd0: begin
        ax_p = pos_x;
        ax_c = center_x;
      end
      2'd1: begin
        ax_p = pos_y;
        ax_c = center_y;
      end
      default: begin
        ax_p = pos_z;
        ax_c = center_z;
      end
    endcase
    ax_d = (ax_p >= ax_c) ? (ax_p - ax_c) : (ax_c - ax_p);
  end

  // Multiplier operands: offsets squared, root times scale, density squared
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_DIST: begin
        mul_a = rsdh_pkg::MUL_W'(ax_d);
        mul_b = rsdh_pkg::MUL_W'(ax_d);
      end
      S_IDX: begin
        mul_a = rsdh_pkg::MUL_W'(iu_result[rsdh_pkg::ROOT_W-1:0]);
        mul_b = rsdh_pkg::MUL_W'(shells_per_box);
      end
      S_CHK: begin
        mul_a = density;
        mul_b = density;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Shell index = floor(root * shells_per_box / 2^24)
  assign idx_full = prod[rsdh_pkg::POS_W +: rsdh_pkg::IDX_FULL_W];
  assign in_range = (idx_full < rsdh_pkg::IDX_FULL_W'(shells_in_use)) &&
                    (idx_full < rsdh_pkg::IDX_FULL_W'(rsdh_pkg::MAX_SHELLS));

  // RAM read address and entry decode; invalid shells read as empty
  assign ram_raddr = (state == S_CHK) ? idx_full[rsdh_pkg::SHELL_AW-1:0] : sel;
  assign rd_shell  = (state == S_ACC) ? idx : sel;
  assign rd_entry  = vld[rd_shell] ? rsdh_pkg::shell_entry_t'(ram_rdata)
                                   : rsdh_pkg::shell_entry_t'('0);

  // Accumulate: saturating sums, count +1 (full count blocks the update)
  assign sum_add = {1'b0, rd_entry.sum} + {1'b0, rsdh_pkg::SUM_W'(density)};
  assign sq_add  = {1'b0, rd_entry.sq_sum} +
                   {1'b0, {rsdh_pkg::SQ_FRAC{1'b0}}, prod[2*rsdh_pkg::MUL_W-1:rsdh_pkg::SQ_FRAC]};

  always_comb begin
    acc_entry        = rd_entry;
    acc_entry.sum    = sum_add[rsdh_pkg::SUM_W] ? '1 : sum_add[rsdh_pkg::SUM_W-1:0];
    acc_entry.sq_sum = sq_add[rsdh_pkg::SUM_W]  ? '1 : sq_add[rsdh_pkg::SUM_W-1:0];
    acc_entry.cnt    = rd_entry.cnt + 1'b1;
  end

  assign new_entry = acc_entry;
  assign ram_we    = (state == S_ACC) && (rd_entry.cnt != '1);

  rsdh_ram #(
    .WIDTH ($bits(rsdh_pkg::shell_entry_t)),
    .DEPTH (rsdh_pkg::MAX_SHELLS)
  ) u_shell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (new_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared unit requests
  always_comb begin
    iu_ctrl.start = 1'b0;
    iu_ctrl.op    = rsdh_pkg::IU_DIV;
    iu_num        = rsdh_pkg::ITER_W'(d2);
    iu_den        = cnt_r;
    case (state)
      S_SQRT_GO: begin
        iu_ctrl.start = 1'b1;
        iu_ctrl.op    = rsdh_pkg::IU_SQRT;
      end
      S_RDATA: begin
        iu_ctrl.start = (rd_entry.cnt != '0);
        iu_num        = rd_entry.sum;
        iu_den        = rd_entry.cnt;
      end
      S_DIV2_GO: begin
        iu_ctrl.start = 1'b1;
        iu_num        = sq_sum_r;
      end
      default: ;
    endcase
  end

  rsdh_iter_unit u_iter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (iu_ctrl),
    .num    (iu_num),
    .den    (iu_den),
    .stat   (iu_stat),
    .result (iu_result)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vld      <= '0;
      m_tvalid <= 1'b0;
      axis     <= '0;
    end else begin
      // S_DONE drives the valid flag itself
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            pos_x   <= s_tdata[23:0];
            pos_y   <= s_tdata[47:24];
            pos_z   <= s_tdata[71:48];
            density <= s_tdata[103:72];
            sel     <= s_tdata[110:104];
            d2      <= '0;
            axis    <= '0;
            if (s_tuser) begin
              state <= S_RADDR;
            end else if (dens_pos) begin
              state <= S_DIST;
            end
          end
        end
        S_DIST: begin
          // prod carries the previous axis square
          if (axis != 2'd0) begin
            d2 <= d2 + prod[rsdh_pkg::D2_W-1:0];
          end
          axis <= axis + 1'b1;
          if (axis == 2'd3) begin
            state <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: state <= S_SQRT;
        S_SQRT: begin
          if (iu_stat.done) begin
            state <= S_IDX;
          end
        end
        S_IDX: state <= S_CHK;
        S_CHK: begin
          idx <= idx_full[rsdh_pkg::SHELL_AW-1:0];
          state <= in_range ? S_ACC : S_IDLE;
        end
        S_ACC: begin
          if (rd_entry.cnt != '1) begin
            vld[idx] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_RADDR: state <= S_RDATA;
        S_RDATA: begin
          // read clears the shell
          vld[sel] <= 1'b0;
          sq_sum_r <= rd_entry.sq_sum;
          cnt_r    <= rd_entry.cnt;
          if (rd_entry.cnt == '0) begin
            mean1_r <= '0;
            mean2_r <= '0;
            state   <= S_DONE;
          end else begin
            state <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (iu_stat.done) begin
            mean1_r <= (iu_result[rsdh_pkg::ITER_W-1:rsdh_pkg::MEAN1_W] != '0) ?
                       '1 : iu_result[rsdh_pkg::MEAN1_W-1:0];
            state   <= S_DIV2_GO;
          end
        end
        S_DIV2_GO: state <= S_DIV2;
        S_DIV2: begin
          if (iu_stat.done) begin
            mean2_r <= iu_result[rsdh_pkg::ITER_W-1] ?
                       '1 : iu_result[rsdh_pkg::MEAN2_W-1:0];
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid    <= 1'b1;
            out_index   <= sel;
            out_mean    <= mean1_r;
            out_mean_sq <= mean2_r;
            out_count   <= cnt_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {3'b000, out_count, out_mean_sq, out_mean, out_index};

endmodule

FILE: rtl/core/rsdh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rsdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/rsdh_iter_unit.sv
// Shared bit-serial unit: restoring square root and restoring division on one subtractor.
`timescale 1ns / 1ps

module rsdh_iter_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  rsdh_pkg::iu_ctrl_t             ctrl,
  input  logic [rsdh_pkg::ITER_W-1:0]    num,
  input  logic [rsdh_pkg::CNT_W-1:0]     den,
  output rsdh_pkg::iu_stat_t             stat,
  output logic [rsdh_pkg::ITER_W-1:0]    result
);

  logic                          busy;
  logic                          done;
  rsdh_pkg::iu_op_t              op;
  logic [rsdh_pkg::STEP_W-1:0]   steps;
  logic [rsdh_pkg::REM_W-1:0]    rem;
  logic [rsdh_pkg::ITER_W-1:0]   quo;
  logic [rsdh_pkg::ITER_W-1:0]   shreg;
  logic [rsdh_pkg::CNT_W-1:0]    den_r;

  logic [rsdh_pkg::REM_W-1:0]    rem_sh;
  logic [rsdh_pkg::REM_W-1:0]    trial;
  logic [rsdh_pkg::REM_W:0]      diff;
  logic                          ge;

  // One compare-subtract per cycle; sqrt brings in two radicand bits, divide one.
  always_comb begin
    if (op == rsdh_pkg::IU_SQRT) begin
      rem_sh = {rem[rsdh_pkg::REM_W-3:0], shreg[rsdh_pkg::ITER_W-1 -: 2]};
      trial  = {quo[rsdh_pkg::REM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[rsdh_pkg::REM_W-2:0], shreg[rsdh_pkg::ITER_W-1]};
      trial  = {2'b00, den_r};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[rsdh_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      op    <= ctrl.op;
      rem   <= '0;
      quo   <= '0;
      den_r <= den;
      if (ctrl.op == rsdh_pkg::IU_SQRT) begin
        shreg <= {num[rsdh_pkg::D2_W-1:0], {(rsdh_pkg::ITER_W - rsdh_pkg::D2_W){1'b0}}};
        steps <= rsdh_pkg::STEP_W'(rsdh_pkg::SQRT_STEPS - 1);
      end else begin
        shreg <= num;
        steps <= rsdh_pkg::STEP_W'(rsdh_pkg::DIV_STEPS - 1);
      end
    end else if (busy) begin
      rem   <= ge ? diff[rsdh_pkg::REM_W-1:0] : rem_sh;
      quo   <= {quo[rsdh_pkg::ITER_W-2:0], ge};
      shreg <= (op == rsdh_pkg::IU_SQRT) ? (shreg << 2) : (shreg << 1);
      steps <= steps - 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = quo;

endmodule

FILE: rtl/core/rsdh_checker.sv
// Port-level assertions for the radial shell density histogram, bound to the top level.
`timescale 1ns / 1ps

module rsdh_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rsdh_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  // Empty shell reports zero means
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[132:101] == '0) |-> (m_tdata[100:7] == '0))
    else $error("empty shell with nonzero mean");

  // Pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[135:133] == '0))
    else $error("result pad bits set");

  // Reset drops any pending result and leaves the input side ready
  a_reset: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("state survived reset");

endmodule

bind radial_shell_density_histogram rsdh_checker u_rsdh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: verif/tb_radial_shell_density_histogram.sv
// Self-checking testbench for the radial shell density histogram: directed table, then random phases.
`timescale 1ns / 1ps

module tb_radial_shell_density_histogram;
  import rsdh_pkg::*;

  // Cycles to let a particle or a read finish after the last report
  localparam int SETTLE_CYCLES   = 200;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 300;

  // Item kinds carried on s_tuser
  localparam logic KIND_PARTICLE = 1'b0;
  localparam logic KIND_READ     = 1'b1;

  // Register indexes the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint POS_MAX = (longint'(1) << POS_W) - 1;
  localparam logic [63:0] MEAN1_MAX = (64'd1 << MEAN1_W) - 1;

  typedef struct packed {
    logic              kind;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic [DENS_W-1:0] density;
    logic [SEL_W-1:0]  shell_select;
  } stream_item_t;

  typedef struct packed {
    logic [SEL_W-1:0]   shell_index;
    logic [MEAN1_W-1:0] mean_density;
    logic [MEAN2_W-1:0] mean_density_sq;
    logic [CNT_W-1:0]   particle_count;
  } shell_report_t;

  // Directed row: zero_report marks a read whose answer is known to be all zero
  typedef struct packed {
    stream_item_t item;
    logic         zero_report;
  } dir_row_t;

  // DUT signals; the ones the bench drives are known from time zero
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tuser   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Predicted histogram contents and register copies
  logic [SUM_W-1:0] shell_sum    [MAX_SHELLS];
  logic [SUM_W-1:0] shell_sq_sum [MAX_SHELLS];
  logic [CNT_W-1:0] shell_cnt    [MAX_SHELLS];
  logic [POS_W-1:0] cfg_center_x, cfg_center_y, cfg_center_z;
  logic [SPB_W-1:0] cfg_spb;
  logic [LIM_W-1:0] cfg_siu;

  shell_report_t pending_reports[$];
  dir_row_t      dir_rows[$];
  int            fail_count = 0;
  bit            calm = 1'b0;   // no idling on either side while set
  int            stall_left = 0;

  radial_shell_density_histogram u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (every item a read, longest stalls and gaps)
  initial begin
    #(25_000_000);
    $display("tb_radial_shell_density_histogram: FAIL");
    $finish;
  end

  // Idle lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // floor(sqrt(v)), one result bit per pass from the top
  function automatic logic [ROOT_W-1:0] root_floor(input logic [63:0] v);
    logic [63:0] r, t;
    int          i;
    r = '0;
    for (i = ROOT_W - 1; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r[ROOT_W-1:0];
  endfunction

  // Bin one particle into its shell; skip bad density, out-of-range shell, full count
  function automatic void accumulate_particle(input stream_item_t it);
    logic [63:0] dx, dy, dz, radius, idx, dd, dsq;
    int          lim;
    if (it.density == '0 || it.density[DENS_W-1]) return;
    dx = (it.pos_x >= cfg_center_x) ? 64'(it.pos_x - cfg_center_x) : 64'(cfg_center_x - it.pos_x);
    dy = (it.pos_y >= cfg_center_y) ? 64'(it.pos_y - cfg_center_y) : 64'(cfg_center_y - it.pos_y);
    dz = (it.pos_z >= cfg_center_z) ? 64'(it.pos_z - cfg_center_z) : 64'(cfg_center_z - it.pos_z);
    radius = 64'(root_floor(dx * dx + dy * dy + dz * dz));
    idx    = (radius * 64'(cfg_spb)) >> POS_W;
    lim    = (cfg_siu > MAX_SHELLS) ? MAX_SHELLS : int'(cfg_siu);
    if (idx >= 64'(lim)) return;
    if (shell_cnt[idx[SHELL_AW-1:0]] == '1) return;
    dd  = 64'(it.density);
    dsq = (dd * dd) >> SQ_FRAC;
    shell_sum[idx[SHELL_AW-1:0]]    = sat_add(shell_sum[idx[SHELL_AW-1:0]], dd);
    shell_sq_sum[idx[SHELL_AW-1:0]] = sat_add(shell_sq_sum[idx[SHELL_AW-1:0]], dsq);
    shell_cnt[idx[SHELL_AW-1:0]]    = shell_cnt[idx[SHELL_AW-1:0]] + 1'b1;
  endfunction

  // Means and count of one shell, then clear it
  function automatic shell_report_t read_and_clear(input logic [SEL_W-1:0] sel);
    shell_report_t rep;
    logic [63:0]   q1, q2;
    rep = '0;
    rep.shell_index    = sel;
    rep.particle_count = shell_cnt[sel];
    if (shell_cnt[sel] != '0) begin
      q1 = shell_sum[sel] / 64'(shell_cnt[sel]);
      q2 = shell_sq_sum[sel] / 64'(shell_cnt[sel]);
      rep.mean_density    = (q1 > MEAN1_MAX) ? '1 : q1[MEAN1_W-1:0];
      rep.mean_density_sq = q2[63] ? '1 : q2[MEAN2_W-1:0];
    end
    shell_sum[sel]    = '0;
    shell_sq_sum[sel] = '0;
    shell_cnt[sel]    = '0;
    return rep;
  endfunction

  task automatic add_row(input logic kind, input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                         input logic [POS_W-1:0] pz, input logic [DENS_W-1:0] dens,
                         input logic [SEL_W-1:0] sel, input logic zero_rep);
    dir_row_t row;
    row.item.kind         = kind;
    row.item.pos_x        = px;
    row.item.pos_y        = py;
    row.item.pos_z        = pz;
    row.item.density      = dens;
    row.item.shell_select = sel;
    row.zero_report       = zero_rep;
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at a falling edge with s_tvalid possibly still high
  task automatic send_item(input stream_item_t it, input logic zero_report, input int gap);
    shell_report_t rep;
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {1'b0, it.shell_select, it.density, it.pos_z, it.pos_y, it.pos_x};
    do @(posedge clk); while (!s_tready);
    // transaction accepted at this edge: predict in order
    if (it.kind == KIND_READ) begin
      rep = read_and_clear(it.shell_select);
      if (zero_report) begin
        rep = '0;
        rep.shell_index = it.shell_select;
      end
      pending_reports.push_back(rep);
    end else begin
      accumulate_particle(it);
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    case (idx)
      REG_CENTER_X:       cfg_center_x = data[POS_W-1:0];
      REG_CENTER_Y:       cfg_center_y = data[POS_W-1:0];
      REG_CENTER_Z:       cfg_center_z = data[POS_W-1:0];
      REG_SHELLS_PER_BOX: cfg_spb      = data[SPB_W-1:0];
      REG_SHELLS_IN_USE:  cfg_siu      = data[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // Hold the sender until every expected report has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    if (calm || stall_left == 0) begin
      m_tready   <= 1'b1;
      stall_left = calm ? 0 : pick_gap();
    end else begin
      m_tready   <= 1'b0;
      stall_left = stall_left - 1;
    end
  end

  // Report checker: every output transaction against the oldest prediction
  always @(posedge clk) begin
    shell_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.shell_index     = m_tdata[6:0];
      got.mean_density    = m_tdata[37:7];
      got.mean_density_sq = m_tdata[100:38];
      got.particle_count  = m_tdata[132:101];
      if (pending_reports.size() == 0) begin
        $error("unexpected report transaction, shell_index %0d", got.shell_index);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (got.shell_index !== want.shell_index) begin
          $error("shell_index: expected %0d, actual %0d", want.shell_index, got.shell_index);
          fail_count++;
        end
        if (got.mean_density !== want.mean_density) begin
          $error("mean_density: expected %0d, actual %0d", want.mean_density, got.mean_density);
          fail_count++;
        end
        if (got.mean_density_sq !== want.mean_density_sq) begin
          $error("mean_density_sq: expected %0d, actual %0d",
                 want.mean_density_sq, got.mean_density_sq);
          fail_count++;
        end
        if (got.particle_count !== want.particle_count) begin
          $error("particle_count: expected %0d, actual %0d",
                 want.particle_count, got.particle_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stream_item_t     it;
    logic [POS_W-1:0] pos[3];
    longint           ctr[3];
    longint           lim_eff, reach, r, off, p;
    int               phase, n, a, axis, roll, dsel;

    for (int i = 0; i < MAX_SHELLS; i++) begin
      shell_sum[i]    = '0;
      shell_sq_sum[i] = '0;
      shell_cnt[i]    = '0;
    end
    cfg_center_x = CENTER_X_RST;
    cfg_center_y = CENTER_Y_RST;
    cfg_center_z = CENTER_Z_RST;
    cfg_spb      = SHELLS_PER_BOX_RST;
    cfg_siu      = SHELLS_IN_USE_RST;

    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, reset settings (100 shells, 10000 per box).
    // A shell index step is 1677.7216 position LSBs here.
    add_row(KIND_READ, '0, '0, '0, '0, 7'd0, 1'b1);      // empty after reset
    add_row(KIND_READ, '0, '0, '0, '0, 7'd127, 1'b1);    // top of storage
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST, 32'h0000_0001, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST, 32'h7FFF_FFFF, 7'd0, 1'b0);
    // non-positive density: ignored
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST, 32'h0000_0000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST, 32'h8000_0000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST, 32'hFFFF_FFFF, 7'd0, 1'b0);
    // box corners: far beyond the shells in use
    add_row(KIND_PARTICLE, '0, '0, '0, 32'h0001_0000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, '1, '1, '1, 32'h0001_0000, 7'd0, 1'b0);
    // just into shell 1 from either side
    add_row(KIND_PARTICLE, CENTER_X_RST + 24'd1678, CENTER_Y_RST, CENTER_Z_RST,
            32'h0002_8000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST - 24'd1678, CENTER_Y_RST, CENTER_Z_RST,
            32'h0000_8000, 7'd0, 1'b0);
    // last shell in use, then first shell past it
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST + 24'd167772, CENTER_Z_RST,
            32'h0003_0000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, CENTER_Z_RST + 24'd167773,
            32'h0003_0000, 7'd0, 1'b0);
    add_row(KIND_PARTICLE, CENTER_X_RST, CENTER_Y_RST, '0, 32'h0000_FFFF, 7'd0, 1'b0);
    add_row(KIND_READ, '0, '0, '0, '0, 7'd0, 1'b0);
    add_row(KIND_READ, '0, '0, '0, '0, 7'd0, 1'b1);      // cleared by the read before
    add_row(KIND_READ, '0, '0, '0, '0, 7'd1, 1'b0);
    add_row(KIND_READ, '0, '0, '0, '0, 7'd99, 1'b0);
    add_row(KIND_READ, '0, '0, '0, '0, 7'd100, 1'b1);    // never reached
    add_row(KIND_READ, '0, '0, '0, '0, 7'd68, 1'b0);
    add_row(KIND_READ, '0, '0, '0, '0, 7'd5, 1'b1);      // untouched shell

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].zero_report, pick_gap());

    for (phase = 0; phase < N_PHASES; phase++) begin
      // registers change only with the block idle
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clk);
      calm = (phase == 2);
      case (phase)
        0: begin
          write_reg(REG_CENTER_X, 24'($urandom));
          write_reg(REG_CENTER_Y, 24'($urandom));
          write_reg(REG_CENTER_Z, 24'($urandom));
          write_reg(REG_SHELLS_PER_BOX, 24'd4096);
          write_reg(REG_SHELLS_IN_USE, 24'd64);
        end
        1: begin
          // origin corner, finest shells, all of storage
          write_reg(REG_CENTER_X, 24'd0);
          write_reg(REG_CENTER_Y, 24'd0);
          write_reg(REG_CENTER_Z, 24'd0);
          write_reg(REG_SHELLS_PER_BOX, 24'd65535);
          write_reg(REG_SHELLS_IN_USE, 24'd128);
        end
        2: begin
          // far corner, one shell as wide as the box
          write_reg(REG_CENTER_X, 24'hFF_FFFF);
          write_reg(REG_CENTER_Y, 24'hFF_FFFF);
          write_reg(REG_CENTER_Z, 24'hFF_FFFF);
          write_reg(REG_SHELLS_PER_BOX, 24'd1);
          write_reg(REG_SHELLS_IN_USE, 24'd1);
        end
        3: begin
          // upper data bits must be dropped; shells in use ends up zero
          write_reg(REG_CENTER_X, 24'($urandom));
          write_reg(REG_CENTER_Y, 24'($urandom));
          write_reg(REG_CENTER_Z, 24'($urandom));
          write_reg(REG_SHELLS_PER_BOX, 24'hA5_0000 | 24'd2000);
          write_reg(REG_SHELLS_IN_USE, 24'h3C_5A00);
        end
        4: begin
          // shells in use above storage: clamps to all shells
          write_reg(REG_CENTER_X, 24'($urandom));
          write_reg(REG_CENTER_Y, 24'($urandom));
          write_reg(REG_CENTER_Z, 24'($urandom));
          write_reg(REG_SHELLS_PER_BOX, 24'd300);
          write_reg(REG_SHELLS_IN_USE, 24'd200);
        end
        default: begin
          write_reg(REG_CENTER_X, 24'($urandom));
          write_reg(REG_CENTER_Y, 24'($urandom));
          write_reg(REG_CENTER_Z, 24'($urandom));
          write_reg(REG_SHELLS_PER_BOX, 24'($urandom_range(1, 65535)));
          write_reg(REG_SHELLS_IN_USE, 24'($urandom_range(1, 128)));
        end
      endcase
      // spare index: must not touch any register
      write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 24'($urandom));
      cfg_we <= 1'b0;

      // radius out to the outer edge of shell lim_eff - 1, capped at the box edge
      lim_eff = (cfg_siu == 0 || cfg_siu > MAX_SHELLS) ? MAX_SHELLS : longint'(cfg_siu);
      reach   = (lim_eff << POS_W) / longint'(cfg_spb);
      if (reach > POS_MAX) reach = POS_MAX;
      ctr[0] = cfg_center_x;
      ctr[1] = cfg_center_y;
      ctr[2] = cfg_center_z;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_idle();
        // start from noise in every field
        it.pos_x        = 24'($urandom);
        it.pos_y        = 24'($urandom);
        it.pos_z        = 24'($urandom);
        it.density      = $urandom;
        it.shell_select = 7'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 18) begin
          it.kind = KIND_READ;
          if ($urandom_range(0, 9) < 8)
            it.shell_select = 7'($urandom_range(0, 32'(lim_eff - 1)));
        end else begin
          it.kind = KIND_PARTICLE;
          if (roll < 90) begin
            // near the center: one major axis, two minor ones
            r    = $urandom_range(0, 32'(reach + reach / 8));
            axis = $urandom_range(0, 2);
            for (a = 0; a < 3; a++) begin
              off = (a == axis) ? r : longint'($urandom_range(0, 32'(r / 4)));
              p   = $urandom_range(0, 1) ? ctr[a] + off : ctr[a] - off;
              if (p < 0) p = 0;
              if (p > POS_MAX) p = POS_MAX;
              pos[a] = p[POS_W-1:0];
            end
            it.pos_x = pos[0];
            it.pos_y = pos[1];
            it.pos_z = pos[2];
          end
          dsel = $urandom_range(0, 9);
          if (dsel == 0) begin
            it.density = '0;
          end else if (dsel == 1) begin
            it.density = $urandom | 32'h8000_0000;
          end else if (dsel < 6) begin
            it.density = $urandom_range(1, 32'h0008_0000);
          end else begin
            it.density = $urandom & 32'h7FFF_FFFF;
            if (it.density == '0) it.density = 32'h0000_0001;
          end
        end
        send_item(it, 1'b0, calm ? 0 : pick_gap());
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_radial_shell_density_histogram: PASS");
    end else begin
      $display("tb_radial_shell_density_histogram: FAIL");
    end
    $finish;
  end

endmodule
